// ===== hw/rtl/sqtc_pkg.sv =====
package sqtc_pkg;

	localparam int MAX_KEYWORD_LEN = 16;
	localparam int KW_W = 8 * MAX_KEYWORD_LEN;
	localparam int KW_IW = $clog2(MAX_KEYWORD_LEN);
	localparam int KW_COUNT = 92;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		C_SPACE    = 4'd0,
		C_NEWLINE  = 4'd1,
		C_TAB      = 4'd2,
		C_STRING   = 4'd3,
		C_COMMENT  = 4'd4,
		C_BRACKET  = 4'd5,
		C_OPER     = 4'd6,
		C_NUMBER   = 4'd7,
		C_KEYWORD  = 4'd8,
		C_VARIABLE = 4'd9
	} tok_class_t;

	// ASCII characters the lexer looks at
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_LBRC   = 8'h7B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_RBRC   = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	typedef logic [MAX_KEYWORD_LEN-1:0][7:0] word_t;

	typedef struct packed {
		tok_class_t  cls;
		logic [15:0] len;
		logic        clip;
		logic        last;
		logic        done;
	} rec_t;

	typedef struct packed {
		logic [1:0] n;
		rec_t       r0;
		rec_t       r1;
	} step_t;

	// Keywords, right aligned and zero padded, first character in the highest used byte
	localparam logic [KW_W-1:0] KW_TABLE [KW_COUNT] = '{
		"SELECT", "FROM", "WHERE", "INSERT", "UPDATE", "DELETE", "CREATE", "DROP",
		"ALTER", "TABLE", "INDEX", "VIEW", "PROCEDURE", "FUNCTION", "TRIGGER",
		"DATABASE", "SCHEMA", "PRIMARY", "FOREIGN", "KEY", "CONSTRAINT", "UNIQUE",
		"NOT", "NULL", "DEFAULT", {"AUTO_", "INCREMENT"}, "INCREMENT", "VALUES", "INTO",
		"SET", "AS", "JOIN", "INNER", "LEFT", "RIGHT", "OUTER", "ON", "GROUP", "BY",
		"HAVING", "ORDER", "ASC", "DESC", "LIMIT", "OFFSET", "DISTINCT", "BETWEEN",
		"LIKE", "IN", "EXISTS", "ALL", "ANY", "UNION", "INTERSECT", "EXCEPT", "CASE",
		"WHEN", "THEN", "ELSE", "END", "BEGIN", "IF", "FOR", "WHILE", "DO", "LOOP",
		"DECLARE", "COMMIT", "ROLLBACK", "SAVEPOINT", "TRANSACTION", "WITH", "USING",
		"FETCH", "FIRST", "NEXT", "ROWS", "ONLY", "SHARE", "LOCK", "OF", "NOWAIT",
		"WAIT", "SKIP", "UNLOCK", "REPLACE", "TEMPORARY", "TEMP", "OR", "AND",
		"TRUE", "FALSE"
	};

	// Word class of a buffered word: keyword on an exact table match
	function automatic tok_class_t word_class(word_t wb, logic [15:0] len, logic too_long);
		logic [KW_W-1:0] w;
		logic [KW_IW-1:0] idx;
		logic hit;
		w = '0;
		hit = 1'b0;
		for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
			idx = KW_IW'(len - 16'(i) - 16'd1);
			if (16'(i) < len) begin
				w[8*i +: 8] = wb[idx];
			end
		end
		if (!too_long && len <= 16'(MAX_KEYWORD_LEN)) begin
			for (int k = 0; k < KW_COUNT; k++) begin
				if (w == KW_TABLE[k]) begin
					hit = 1'b1;
				end
			end
		end
		return hit ? C_KEYWORD : C_VARIABLE;
	endfunction

endpackage

// ===== hw/rtl/sqtc_in_if.sv =====
interface sqtc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== hw/rtl/sqtc_out_if.sv =====
interface sqtc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_class;
	logic [15:0] token_length;
	logic        length_clipped;
	logic        last_of_run;
	logic        text_done;

	modport source (output valid, output token_class, output token_length,
		output length_clipped, output last_of_run, output text_done, input ready);
	modport sink (input valid, input token_class, input token_length,
		input length_clipped, input last_of_run, input text_done, output ready);
endinterface

// ===== hw/rtl/sql_token_classifier_core.sv =====
// Channel    Dir  Payload
// text_in    in   text_byte[7:0], final_byte
// token_out  out  token_class[3:0], token_length[15:0], length_clipped,
//                 last_of_run, text_done
//
// One byte per cycle is accepted; the lexer step and keyword match are done in the
// accept cycle and the records land in a four-entry result queue.
// A byte yields zero, one or two records; the output drains one per ready cycle.
// text_in.ready drops while the queue has fewer than two free entries.
// arst_n returns the lexer to idle with no pending token and empties the queue.
module sql_token_classifier_core (
	input  logic  clk,
	input  logic  arst_n,
	sqtc_in_if.sink    text_in,
	sqtc_out_if.source token_out
);
	import sqtc_pkg::*;

	step_t step;
	rec_t  head;
	logic  room;
	logic  fire;

	// Accept a transaction when the queue can take a full step
	assign text_in.ready = room;
	assign fire = text_in.valid && room;

	sqtc_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.text_byte  (text_in.text_byte),
		.final_byte (text_in.final_byte),
		.step       (step)
	);

	sqtc_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.step   (step),
		.room   (room),
		.valid  (token_out.valid),
		.pop    (token_out.ready),
		.head   (head)
	);

	// Drive the result payload from the queue head
	assign token_out.token_class = head.cls;
	assign token_out.token_length = head.len;
	assign token_out.length_clipped = head.clip;
	assign token_out.last_of_run = head.last;
	assign token_out.text_done = head.done;
endmodule

// ===== hw/rtl/sqtc_lexer.sv =====
module sqtc_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        text_byte,
	input  logic              final_byte,
	output sqtc_pkg::step_t   step
);
	import sqtc_pkg::*;

	typedef enum logic [13:0] {
		M_IDLE  = 14'b00000000000001,
		M_STR   = 14'b00000000000010,
		M_ESC   = 14'b00000000000100,
		M_DASH  = 14'b00000000001000,
		M_LINE  = 14'b00000000010000,
		M_SLASH = 14'b00000000100000,
		M_BLOCK = 14'b00000001000000,
		M_BSTAR = 14'b00000010000000,
		M_EQ    = 14'b00000100000000,
		M_BANG  = 14'b00001000000000,
		M_LT    = 14'b00010000000000,
		M_GT    = 14'b00100000000000,
		M_NUM   = 14'b01000000000000,
		M_WORD  = 14'b10000000000000
	} mode_t;

	typedef struct packed {
		logic       emit;
		tok_class_t cls;
		logic       start;
		mode_t      mode;
		logic       quote;
		logic       word;
	} fresh_t;

	mode_t       mode_q, v_mode;
	logic        qd_q, v_qd;
	logic [15:0] cnt_q, v_cnt;
	logic        clip_q, v_clip;
	logic        wtl_q, v_wtl;
	word_t       buf_q, v_buf;
	logic        w_en;
	logic [KW_IW-1:0] w_idx;
	logic        a_en, b_en, c_en;
	rec_t        a_rec, b_rec, c_rec;
	fresh_t      fr;
	logic        do_fresh;

	function automatic logic is_digit(logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic logic is_word(logic [7:0] b);
		return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) || b == CH_UNDER;
	endfunction

	// Decode a byte that starts a new token
	function automatic fresh_t fresh_f(logic [7:0] b);
		fresh_t f;
		f = '{emit: 1'b0, cls: C_VARIABLE, start: 1'b0, mode: M_IDLE, quote: 1'b0,
			word: 1'b0};
		case (b)
			CH_SPACE: begin f.emit = 1'b1; f.cls = C_SPACE; end
			CH_LF: begin f.emit = 1'b1; f.cls = C_NEWLINE; end
			CH_TAB: begin f.emit = 1'b1; f.cls = C_TAB; end
			CH_DQUOTE, CH_SQUOTE: begin f.start = 1'b1; f.mode = M_STR; f.quote = 1'b1; end
			CH_DASH: begin f.start = 1'b1; f.mode = M_DASH; end
			CH_SLASH: begin f.start = 1'b1; f.mode = M_SLASH; end
			CH_LBRC, CH_RBRC, CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR: begin
				f.emit = 1'b1; f.cls = C_BRACKET;
			end
			CH_EQ: begin f.start = 1'b1; f.mode = M_EQ; end
			CH_BANG: begin f.start = 1'b1; f.mode = M_BANG; end
			CH_LT: begin f.start = 1'b1; f.mode = M_LT; end
			CH_GT: begin f.start = 1'b1; f.mode = M_GT; end
			CH_AMP, CH_PIPE, CH_CARET, CH_TILDE: begin f.emit = 1'b1; f.cls = C_OPER; end
			default: begin
				if (is_digit(b)) begin
					f.start = 1'b1; f.mode = M_NUM;
				end else if (is_word(b)) begin
					f.start = 1'b1; f.mode = M_WORD; f.word = 1'b1;
				end else begin
					f.emit = 1'b1; f.cls = C_VARIABLE;
				end
			end
		endcase
		return f;
	endfunction

	// Step the lexer on one byte, then flush on the final byte
	always_comb begin
		v_mode = mode_q;
		v_qd = qd_q;
		v_cnt = cnt_q;
		v_clip = clip_q;
		v_wtl = wtl_q;
		w_en = 1'b0;
		w_idx = cnt_q[KW_IW-1:0];
		a_en = 1'b0;
		a_rec = '{cls: C_VARIABLE, len: cnt_q, clip: clip_q, last: 1'b0, done: 1'b0};
		b_en = 1'b0;
		c_en = 1'b0;
		c_rec = a_rec;
		do_fresh = 1'b0;
		fr = fresh_f(text_byte);

		case (mode_q)
			M_STR: begin
				if (cnt_q == 16'hFFFF) v_clip = 1'b1; else v_cnt = cnt_q + 16'd1;
				if (text_byte == CH_BSLASH) begin
					v_mode = M_ESC;
				end else if (text_byte == (qd_q ? CH_DQUOTE : CH_SQUOTE)) begin
					a_en = 1'b1; a_rec.cls = C_STRING; a_rec.len = v_cnt; a_rec.clip = v_clip;
					v_mode = M_IDLE;
				end
			end
			M_ESC: begin
				if (cnt_q == 16'hFFFF) v_clip = 1'b1; else v_cnt = cnt_q + 16'd1;
				v_mode = M_STR;
			end
			M_DASH: begin
				if (text_byte == CH_DASH) begin
					v_cnt = 16'd2; v_mode = M_LINE;
				end else begin
					a_en = 1'b1; a_rec.cls = C_OPER; do_fresh = 1'b1;
				end
			end
			M_LINE: begin
				if (text_byte == CH_LF) begin
					a_en = 1'b1; a_rec.cls = C_COMMENT; do_fresh = 1'b1;
				end else if (cnt_q == 16'hFFFF) begin
					v_clip = 1'b1;
				end else begin
					v_cnt = cnt_q + 16'd1;
				end
			end
			M_SLASH: begin
				if (text_byte == CH_STAR) begin
					v_cnt = 16'd2; v_mode = M_BLOCK;
				end else begin
					a_en = 1'b1; a_rec.cls = C_VARIABLE; do_fresh = 1'b1;
				end
			end
			M_BLOCK: begin
				if (cnt_q == 16'hFFFF) v_clip = 1'b1; else v_cnt = cnt_q + 16'd1;
				if (text_byte == CH_STAR) v_mode = M_BSTAR;
			end
			M_BSTAR: begin
				if (cnt_q == 16'hFFFF) v_clip = 1'b1; else v_cnt = cnt_q + 16'd1;
				if (text_byte == CH_SLASH) begin
					a_en = 1'b1; a_rec.cls = C_COMMENT; a_rec.len = v_cnt; a_rec.clip = v_clip;
					v_mode = M_IDLE;
				end else if (text_byte != CH_STAR) begin
					v_mode = M_BLOCK;
				end
			end
			M_EQ, M_BANG, M_GT, M_LT: begin
				if (text_byte == CH_EQ || (mode_q == M_LT && text_byte == CH_GT)) begin
					if (cnt_q == 16'hFFFF) v_clip = 1'b1; else v_cnt = cnt_q + 16'd1;
					a_en = 1'b1; a_rec.cls = C_OPER; a_rec.len = v_cnt; a_rec.clip = v_clip;
					v_mode = M_IDLE;
				end else begin
					a_en = 1'b1;
					a_rec.cls = (mode_q == M_EQ) ? C_VARIABLE : C_OPER;
					do_fresh = 1'b1;
				end
			end
			M_NUM: begin
				if (is_digit(text_byte) || text_byte == CH_DOT) begin
					if (cnt_q == 16'hFFFF) v_clip = 1'b1; else v_cnt = cnt_q + 16'd1;
				end else begin
					a_en = 1'b1; a_rec.cls = C_NUMBER; do_fresh = 1'b1;
				end
			end
			M_WORD: begin
				if (is_word(text_byte) || is_digit(text_byte)) begin
					if (cnt_q < 16'(MAX_KEYWORD_LEN)) w_en = 1'b1; else v_wtl = 1'b1;
					if (cnt_q == 16'hFFFF) v_clip = 1'b1; else v_cnt = cnt_q + 16'd1;
				end else begin
					a_en = 1'b1; a_rec.cls = word_class(buf_q, cnt_q, wtl_q); do_fresh = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase

		// Start the next token on the same byte
		if (do_fresh) begin
			v_mode = M_IDLE;
			v_cnt = 16'd0;
			v_clip = 1'b0;
			b_en = fr.emit;
			if (fr.start) begin
				v_mode = fr.mode;
				v_cnt = 16'd1;
			end
			if (fr.quote) v_qd = (text_byte == CH_DQUOTE);
			if (fr.word) begin
				w_en = 1'b1;
				w_idx = '0;
				v_wtl = 1'b0;
			end
		end else if (a_en) begin
			v_cnt = 16'd0;
			v_clip = 1'b0;
		end
		b_rec = '{cls: fr.cls, len: 16'd1, clip: 1'b0, last: 1'b0, done: 1'b0};

		v_buf = buf_q;
		if (w_en) v_buf[w_idx] = text_byte;

		// Flush the pending token at end of text
		c_rec.len = v_cnt;
		c_rec.clip = v_clip;
		if (final_byte) begin
			case (v_mode)
				M_STR, M_ESC: begin c_en = 1'b1; c_rec.cls = C_STRING; end
				M_LINE, M_BLOCK, M_BSTAR: begin c_en = 1'b1; c_rec.cls = C_COMMENT; end
				M_SLASH, M_EQ: begin c_en = 1'b1; c_rec.cls = C_VARIABLE; end
				M_DASH, M_BANG, M_LT, M_GT: begin c_en = 1'b1; c_rec.cls = C_OPER; end
				M_NUM: begin c_en = 1'b1; c_rec.cls = C_NUMBER; end
				M_WORD: begin c_en = 1'b1; c_rec.cls = word_class(v_buf, v_cnt, v_wtl); end
				default: c_en = 1'b0;
			endcase
			v_mode = M_IDLE;
			v_cnt = 16'd0;
			v_clip = 1'b0;
			v_qd = 1'b0;
			v_wtl = 1'b0;
		end

		// Pack the records in order
		step.n = 2'(a_en) + 2'(b_en) + 2'(c_en);
		step.r0 = a_en ? a_rec : (b_en ? b_rec : c_rec);
		step.r1 = (a_en && b_en) ? b_rec : c_rec;
		step.r0.last = (step.n == 2'd1);
		step.r0.done = (step.n == 2'd1) && final_byte;
		step.r1.last = 1'b1;
		step.r1.done = final_byte;
	end

	// Hold lexer state, advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			qd_q <= 1'b0;
			cnt_q <= 16'd0;
			clip_q <= 1'b0;
			wtl_q <= 1'b0;
		end else if (fire) begin
			mode_q <= v_mode;
			qd_q <= v_qd;
			cnt_q <= v_cnt;
			clip_q <= v_clip;
			wtl_q <= v_wtl;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && w_en) buf_q[w_idx] <= text_byte;
	end

`ifndef ASSERT_OFF
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && final_byte |=> mode_q == M_IDLE && cnt_q == 16'd0)
		else $error("lexer not idle after final byte");
	a_pending_len: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != M_IDLE |-> cnt_q != 16'd0)
		else $error("pending token with zero length");
	a_two_recs: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step.n == 2'd2 |-> a_en || b_en)
		else $error("two records without a closing token");
`endif
endmodule

// ===== hw/rtl/sqtc_out_fifo.sv =====
module sqtc_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sqtc_pkg::step_t step,
	output logic            room,
	output logic            valid,
	input  logic            pop,
	output sqtc_pkg::rec_t  head
);
	import sqtc_pkg::*;

	rec_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic [1:0]         n_push;
	logic               do_pop;

	// Room for a full two-record step
	assign room = cnt_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign valid = cnt_q != '0;
	assign head = mem_q[rd_q];
	assign n_push = push ? step.n : 2'd0;
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + FIFO_AW'(n_push);
			rd_q <= rd_q + FIFO_AW'(do_pop);
			cnt_q <= cnt_q + FIFO_CW'(n_push) - FIFO_CW'(do_pop);
		end
	end

	// Write up to two records per step
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) mem_q[wr_q] <= step.r0;
		if (n_push == 2'd2) mem_q[wr_q + FIFO_AW'(1)] <= step.r1;
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("record queue overflow");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && n_push == 2'd0 |=> cnt_q == $past(cnt_q) - FIFO_CW'(1))
		else $error("record count did not drop on pop");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && head.done |-> head.last)
		else $error("end of text on a record that is not last");
`endif
endmodule

// ===== test/tb_sql_token_classifier_core.sv =====
module tb_sql_token_classifier_core;
	import sqtc_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 400;

	typedef enum logic [3:0] {
		M_IDLE, M_STR, M_ESC, M_DASH, M_LINE, M_SLASH, M_BLOCK, M_BSTAR,
		M_EQ, M_BANG, M_LT, M_GT, M_NUM, M_WORD
	} lex_mode_t;

	typedef struct {
		tok_class_t  cls;
		logic [15:0] len;
		logic        clip;
		logic        last;
		logic        done;
	} token_rec_t;

	typedef struct {
		logic [7:0]  ch;
		logic        fin;
		int          cls;   // -1: take the expectation from the lexer model
		logic [15:0] len;
	} text_row_t;

	logic clk;
	logic arst_n;
	sqtc_in_if  text_in ();
	sqtc_out_if token_out ();

	sql_token_classifier_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in.sink),
		.token_out(token_out.source)
	);

	string keywords[] = '{
		"SELECT", "FROM", "WHERE", "INSERT", "UPDATE", "DELETE", "CREATE", "DROP",
		"ALTER", "TABLE", "INDEX", "VIEW", "PROCEDURE", "FUNCTION", "TRIGGER",
		"DATABASE", "SCHEMA", "PRIMARY", "FOREIGN", "KEY", "CONSTRAINT", "UNIQUE",
		"NOT", "NULL", "DEFAULT", {"AUTO_", "INCREMENT"}, "INCREMENT", "VALUES", "INTO",
		"SET", "AS", "JOIN", "INNER", "LEFT", "RIGHT", "OUTER", "ON", "GROUP", "BY",
		"HAVING", "ORDER", "ASC", "DESC", "LIMIT", "OFFSET", "DISTINCT", "BETWEEN",
		"LIKE", "IN", "EXISTS", "ALL", "ANY", "UNION", "INTERSECT", "EXCEPT", "CASE",
		"WHEN", "THEN", "ELSE", "END", "BEGIN", "IF", "FOR", "WHILE", "DO", "LOOP",
		"DECLARE", "COMMIT", "ROLLBACK", "SAVEPOINT", "TRANSACTION", "WITH", "USING",
		"FETCH", "FIRST", "NEXT", "ROWS", "ONLY", "SHARE", "LOCK", "OF", "NOWAIT",
		"WAIT", "SKIP", "UNLOCK", "REPLACE", "TEMPORARY", "TEMP", "OR", "AND",
		"TRUE", "FALSE"
	};

	// Directed text: extremes, all kinds but number and keyword, and end-of-text cases
	text_row_t directed[] = '{
		'{CH_SPACE, 0, C_SPACE, 1}, '{CH_LF, 0, C_NEWLINE, 1}, '{CH_TAB, 0, C_TAB, 1},
		'{CH_LPAR, 0, C_BRACKET, 1}, '{CH_RBRC, 0, C_BRACKET, 1},
		'{CH_TILDE, 0, C_OPER, 1}, '{8'hFF, 0, C_VARIABLE, 1}, '{8'h00, 0, C_VARIABLE, 1},
		'{CH_EQ, 0, -1, 0}, '{CH_EQ, 0, C_OPER, 2},
		'{CH_LT, 0, -1, 0}, '{CH_GT, 0, C_OPER, 2},
		'{CH_EQ, 0, -1, 0}, '{"a", 0, -1, 0},
		'{"S", 0, -1, 0}, '{"E", 0, -1, 0}, '{"T", 0, -1, 0}, '{CH_SPACE, 0, -1, 0},
		'{CH_DQUOTE, 0, -1, 0}, '{"x", 0, -1, 0}, '{CH_BSLASH, 1, -1, 0},
		'{CH_DASH, 1, C_OPER, 1},
		'{CH_SLASH, 0, -1, 0}, '{CH_STAR, 0, -1, 0}, '{"9", 1, -1, 0}
	};

	token_rec_t expected_tokens[$];
	int errors = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int stall_cycles = 0;
	int sent = 0;

	// lexer model state
	lex_mode_t   mode;
	logic        dquote;
	logic [15:0] tok_len;
	logic        tok_clip;
	logic [7:0]  word_buf[MAX_KEYWORD_LEN];
	logic        word_long;
	token_rec_t  step_recs[2];
	int          step_n;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic logic is_digit(logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic logic is_word_char(logic [7:0] b);
		return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) || b == CH_UNDER;
	endfunction

	function automatic void emit(tok_class_t c, logic [15:0] l, logic cl);
		if (step_n < 2) begin
			step_recs[step_n] = '{c, l, cl, 1'b0, 1'b0};
			step_n++;
		end
	endfunction

	function automatic void close_token(tok_class_t c);
		emit(c, tok_len, tok_clip);
		mode = M_IDLE;
		tok_len = 0;
		tok_clip = 1'b0;
	endfunction

	function automatic void grow();
		if (tok_len == 16'hFFFF) tok_clip = 1'b1;
		else tok_len++;
	endfunction

	function automatic void open_token(lex_mode_t m);
		mode = m;
		tok_len = 1;
		tok_clip = 1'b0;
	endfunction

	function automatic tok_class_t classify_word();
		string s;
		s = "";
		if (word_long || tok_len > MAX_KEYWORD_LEN) return C_VARIABLE;
		for (int i = 0; i < tok_len; i++) s = {s, string'(word_buf[i])};
		foreach (keywords[k]) if (keywords[k] == s) return C_KEYWORD;
		return C_VARIABLE;
	endfunction

	function automatic void start_token(logic [7:0] b);
		case (b)
			CH_SPACE: emit(C_SPACE, 1, 1'b0);
			CH_LF: emit(C_NEWLINE, 1, 1'b0);
			CH_TAB: emit(C_TAB, 1, 1'b0);
			CH_DQUOTE, CH_SQUOTE: begin
				dquote = (b == CH_DQUOTE);
				open_token(M_STR);
			end
			CH_DASH: open_token(M_DASH);
			CH_SLASH: open_token(M_SLASH);
			CH_LBRC, CH_RBRC, CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR: emit(C_BRACKET, 1, 1'b0);
			CH_EQ: open_token(M_EQ);
			CH_BANG: open_token(M_BANG);
			CH_LT: open_token(M_LT);
			CH_GT: open_token(M_GT);
			CH_AMP, CH_PIPE, CH_CARET, CH_TILDE: emit(C_OPER, 1, 1'b0);
			default: begin
				if (is_digit(b)) begin
					open_token(M_NUM);
				end else if (is_word_char(b)) begin
					open_token(M_WORD);
					word_buf[0] = b;
					word_long = 1'b0;
				end else begin
					emit(C_VARIABLE, 1, 1'b0);
				end
			end
		endcase
	endfunction

	// Advance the lexer model by one byte and queue the tokens it finishes
	function automatic void lex_byte(logic [7:0] b, logic fin);
		step_n = 0;
		case (mode)
			M_STR: begin
				grow();
				if (b == CH_BSLASH) mode = M_ESC;
				else if (b == (dquote ? CH_DQUOTE : CH_SQUOTE)) close_token(C_STRING);
			end
			M_ESC: begin
				grow();
				mode = M_STR;
			end
			M_DASH: begin
				if (b == CH_DASH) begin
					tok_len = 2;
					mode = M_LINE;
				end else begin
					close_token(C_OPER);
					start_token(b);
				end
			end
			M_LINE: begin
				if (b == CH_LF) begin
					close_token(C_COMMENT);
					start_token(b);
				end else begin
					grow();
				end
			end
			M_SLASH: begin
				if (b == CH_STAR) begin
					tok_len = 2;
					mode = M_BLOCK;
				end else begin
					close_token(C_VARIABLE);
					start_token(b);
				end
			end
			M_BLOCK: begin
				grow();
				if (b == CH_STAR) mode = M_BSTAR;
			end
			M_BSTAR: begin
				grow();
				if (b == CH_SLASH) close_token(C_COMMENT);
				else if (b != CH_STAR) mode = M_BLOCK;
			end
			M_EQ, M_BANG, M_GT, M_LT: begin
				if (b == CH_EQ || (mode == M_LT && b == CH_GT)) begin
					grow();
					close_token(C_OPER);
				end else begin
					close_token(mode == M_EQ ? C_VARIABLE : C_OPER);
					start_token(b);
				end
			end
			M_NUM: begin
				if (is_digit(b) || b == CH_DOT) begin
					grow();
				end else begin
					close_token(C_NUMBER);
					start_token(b);
				end
			end
			M_WORD: begin
				if (is_word_char(b) || is_digit(b)) begin
					if (tok_len < MAX_KEYWORD_LEN) word_buf[tok_len] = b;
					else word_long = 1'b1;
					grow();
				end else begin
					close_token(classify_word());
					start_token(b);
				end
			end
			default: begin
				mode = M_IDLE;
				start_token(b);
			end
		endcase
		// flush the pending token at end of text
		if (fin) begin
			case (mode)
				M_STR, M_ESC: close_token(C_STRING);
				M_LINE, M_BLOCK, M_BSTAR: close_token(C_COMMENT);
				M_SLASH, M_EQ: close_token(C_VARIABLE);
				M_DASH, M_BANG, M_LT, M_GT: close_token(C_OPER);
				M_NUM: close_token(C_NUMBER);
				M_WORD: close_token(classify_word());
				default: ;
			endcase
			mode = M_IDLE;
			tok_len = 0;
			tok_clip = 1'b0;
			dquote = 1'b0;
			word_long = 1'b0;
		end
		for (int k = 0; k < step_n; k++) begin
			step_recs[k].last = (k == step_n - 1);
			step_recs[k].done = (k == step_n - 1) && fin;
			expected_tokens.push_back(step_recs[k]);
		end
	endfunction

	// Drive one byte; called at a falling edge, returns at a falling edge
	task automatic send_byte(logic [7:0] b, logic fin, int cls = -1, logic [15:0] len = 0);
		token_rec_t typed;
		while ($urandom_range(99) < in_idle_pct) begin
			text_in.valid = 1'b0;
			@(negedge clk);
		end
		text_in.valid = 1'b1;
		text_in.text_byte = b;
		text_in.final_byte = fin;
		do @(posedge clk); while (!text_in.ready);
		if (cls < 0) begin
			lex_byte(b, fin);
		end else begin
			// typed expectation; the model still advances, its records are dropped
			typed = '{tok_class_t'(cls), len, 1'b0, 1'b1, fin};
			lex_byte(b, fin);
			repeat (step_n) void'(expected_tokens.pop_back());
			expected_tokens.push_back(typed);
		end
		sent++;
		@(negedge clk);
	endtask

	task automatic send_string(string s, logic fin_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fin_at_end && i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	// Build one random text from well-formed tokens with some noise, then send it
	task automatic send_random_text();
		string t;
		string alnum;
		int n;
		t = "";
		alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
		n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 11))
				0, 1: t = {t, keywords[$urandom_range(keywords.size() - 1)]};
				2: begin
					t = {t, string'(pick(alnum.substr(0, 52)))};
					repeat ($urandom_range(0, 20)) t = {t, string'(pick(alnum))};
				end
				3: begin
					t = {t, string'(pick("0123456789"))};
					repeat ($urandom_range(0, 6)) t = {t, string'(pick("0123456789."))};
				end
				4: begin
					t = {t, string'(pick("\"'"))};
					repeat ($urandom_range(0, 8)) t = {t, string'(pick("ab\\'\" *"))};
					if ($urandom_range(3) != 0) t = {t, string'(pick("\"'"))};
				end
				5: begin
					t = {t, "--"};
					repeat ($urandom_range(0, 8)) t = {t, string'(pick("ab -*/"))};
					if ($urandom_range(3) != 0) t = {t, "\n"};
				end
				6: begin
					t = {t, "/*"};
					repeat ($urandom_range(0, 8)) t = {t, string'(pick("ab */"))};
					if ($urandom_range(3) != 0) t = {t, "*/"};
				end
				7: t = {t, string'(pick("=!<>&|^~-/")), string'(pick("=>a -"))};
				8: t = {t, string'(pick("{}[]() \n\t,;"))};
				default: begin
					repeat ($urandom_range(1, 3)) t = {t, string'(8'($urandom_range(1, 255)))};
				end
			endcase
			if ($urandom_range(2) == 0) t = {t, string'(pick(" \n\t"))};
		end
		// strings cannot hold a zero byte, so send it apart now and then
		if ($urandom_range(15) == 0) send_byte(8'h00, 1'b0);
		send_string(t, 1'b1);
	endtask

	// Randomly stall the result side
	always @(negedge clk) begin
		token_out.ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		token_rec_t e;
		if (token_out.valid && token_out.ready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: class %0d length %0d",
					token_out.token_class, token_out.token_length);
				errors++;
			end else begin
				e = expected_tokens.pop_front();
				if (token_out.token_class !== e.cls) begin
					$error("token_class: expected %0d, got %0d", e.cls, token_out.token_class);
					errors++;
				end
				if (token_out.token_length !== e.len) begin
					$error("token_length: expected %0d, got %0d", e.len, token_out.token_length);
					errors++;
				end
				if (token_out.length_clipped !== e.clip) begin
					$error("length_clipped: expected %0b, got %0b", e.clip,
						token_out.length_clipped);
					errors++;
				end
				if (token_out.last_of_run !== e.last) begin
					$error("last_of_run: expected %0b, got %0b", e.last, token_out.last_of_run);
					errors++;
				end
				if (token_out.text_done !== e.done) begin
					$error("text_done: expected %0b, got %0b", e.done, token_out.text_done);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((text_in.valid && text_in.ready) || (token_out.valid && token_out.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		text_in.valid = 1'b0;
		text_in.text_byte = '0;
		text_in.final_byte = 1'b0;
		arst_n = 1'b0;
		mode = M_IDLE;
		dquote = 1'b0;
		tok_len = 0;
		tok_clip = 1'b0;
		word_long = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_byte(directed[i].ch, directed[i].fin, directed[i].cls, directed[i].len);

		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 65 : 0;
			out_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 31 : 0;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) send_random_text();
		end

		// long words around the keyword length limit
		send_string({"AUTO_", "INCREMENTXYZ TRANSACTION abcdefghijklmnop q"}, 1'b1);
		text_in.valid = 1'b0;

		// drain
		while (expected_tokens.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ===== sql_token_classifier_core.f =====
hw/rtl/sqtc_pkg.sv
hw/rtl/sqtc_in_if.sv
hw/rtl/sqtc_out_if.sv
hw/rtl/sqtc_lexer.sv
hw/rtl/sqtc_out_fifo.sv
hw/rtl/sql_token_classifier_core.sv
test/tb_sql_token_classifier_core.sv
